// ----- design/bcrn_pkg.sv -----
// Shared types and constants for the bilinear crop/resize/normalize block.
// No dependencies; the normalizer and the top level refer to this package by scoped names.
package bcrn_pkg;

  // Configuration port
  localparam int CFG_DW = 12;
  localparam int CFG_IW = 3;

  typedef enum logic [CFG_IW-1:0] {
    CFG_SRC_W  = 3'd0,
    CFG_SRC_H  = 3'd1,
    CFG_DST_W  = 3'd2,
    CFG_DST_H  = 3'd3,
    CFG_CROP_L = 3'd4,
    CFG_CROP_T = 3'd5,
    CFG_CROP_R = 3'd6,
    CFG_CROP_B = 3'd7
  } cfg_idx_t;

  // Register reset values
  localparam logic [9:0]  RST_SRC_W  = 10'd512;
  localparam logic [9:0]  RST_SRC_H  = 10'd512;
  localparam logic [8:0]  RST_DST_W  = 9'd192;
  localparam logic [8:0]  RST_DST_H  = 9'd192;
  localparam logic [11:0] RST_CROP_L = 12'd0;
  localparam logic [11:0] RST_CROP_T = 12'd0;
  localparam logic [11:0] RST_CROP_R = 12'd512;
  localparam logic [11:0] RST_CROP_B = 12'd512;

  // Signed width that holds any difference of two clamped crop edges
  localparam int RW_W = 14;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Normalization: out = round(V * 2^14 / (255 * 2^2F)) - 8192, saturated
  localparam int          NORM_SHIFT   = 14;
  localparam int          NORM_OFS     = 8192 * 255;
  localparam logic [31:0] NORM_SAT_U   = 32'd8355840;  // 255 * 32768
  localparam logic [16:0] RECIP_255    = 17'd65793;    // floor(2^24 / 255)
  localparam int          RECIP_SH     = 24;
  localparam logic [23:0] DIV_255      = 24'd255;
  localparam logic signed [15:0] Q_POS_MAX = 16'sh7FFF;
  localparam logic signed [15:0] Q_NEG_MAX = 16'sh8000;

  // Request sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_DIV,
    ST_POS,
    ST_WGT,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_ACC,
    ST_NORM,
    ST_NWAIT,
    ST_DONE
  } state_t;

  // Sequencer strobes for the datapath units
  typedef struct packed {
    logic mem_we;
    logic div_start;
    logic norm_start;
    logic ibuf_pop;
    logic out_load;
  } ctl_t;

endpackage

// ----- design/bcrn_frame_mem.sv -----
// Single-port frame store, one 24-bit RGB pixel per entry, registered read.
// Depends on nothing; instantiated by the top level.
module bcrn_frame_mem #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [23:0]   wdata,
  output logic [23:0]   rdata
);

  logic [23:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- design/bcrn_pos_div.sv -----
// Restoring divider for one sample coordinate: fx = trunc(num * 2^F / div).
// One quotient bit per cycle; no package dependency.
module bcrn_pos_div #(
  parameter int MW        = 21,
  parameter int DIVW      = 10,
  parameter int FRAC_BITS = 12,
  parameter int FXW       = 23
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [MW-1:0]  num,
  input  logic [DIVW-1:0]       div,
  output logic                  done,
  output logic signed [FXW-1:0] fx
);

  localparam int DVW = MW - 1 + FRAC_BITS;
  localparam int CNW = $clog2(DVW + 1);

  logic [DVW-1:0]  dv_r, dv_nxt;
  logic [DIVW-1:0] rem_r, rem_nxt;
  logic [CNW-1:0]  cnt_r, cnt_nxt;
  logic            neg_r;
  logic            busy_r;
  logic            done_r;
  logic [MW-1:0]   mag;
  logic [DIVW:0]   trial;
  logic            ge;

  assign mag = num[MW-1] ? MW'(-num) : MW'(num);

  // One shift-subtract step
  always_comb begin
    trial   = {rem_r, dv_r[DVW-1]};
    ge      = (trial >= {1'b0, div});
    rem_nxt = ge ? DIVW'(trial - {1'b0, div}) : DIVW'(trial);
    dv_nxt  = {dv_r[DVW-2:0], ge};
    cnt_nxt = cnt_r - CNW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNW'(DVW);
    end else if (busy_r) begin
      cnt_r <= cnt_nxt;
      if (cnt_r == CNW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[MW-1];
      dv_r  <= {mag[MW-2:0], {FRAC_BITS{1'b0}}};
      rem_r <= '0;
    end else if (busy_r) begin
      dv_r  <= dv_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign fx   = neg_r ? -FXW'(dv_r) : FXW'(dv_r);

endmodule

// ----- design/bcrn_norm.sv -----
// Five-stage normalizer for three channels: v/127.5 - 1 in Q3.13, saturated.
// Uses bcrn_pkg constants; instantiated by the top level.
module bcrn_norm #(
  parameter int FRAC_BITS = 12,
  parameter int VW        = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [VW-1:0] acc [3],
  output logic                 done,
  output logic signed [15:0]   res [3]
);

  localparam int TW = 2 * FRAC_BITS + 32;

  logic signed [TW-1:0] t_r   [3];
  logic [TW-1:0]        mag_r [3];
  logic [31:0]          u_r   [3];
  logic [22:0]          u23_r [3];
  logic [39:0]          prod_r[3];
  logic                 sat_r [3];
  logic [3:0]           neg_r [3];
  logic [4:0]           vld_r;
  logic                 done_r;

  // Stage logic, channels side by side
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      logic [15:0] qe;
      logic [23:0] rm;
      logic [15:0] q;
      qe = prod_r[c][RECIP_SH_TOP:bcrn_pkg::RECIP_SH];
      rm = 24'(u23_r[c]) - 24'(qe) * bcrn_pkg::DIV_255;
      q  = (rm >= bcrn_pkg::DIV_255) ? qe + 16'd1 : qe;
      // s1: offset product
      t_r[c]    <= (TW'(acc[c]) <<< bcrn_pkg::NORM_SHIFT)
                   - (TW'(bcrn_pkg::NORM_OFS) << (2 * FRAC_BITS));
      // s2: magnitude
      mag_r[c]  <= t_r[c][TW-1] ? TW'(-t_r[c]) : TW'(t_r[c]);
      neg_r[c]  <= {neg_r[c][2:0], t_r[c][TW-1]};
      // s3: add half and drop fraction
      u_r[c]    <= 32'((mag_r[c] + (TW'(255) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS));
      // s4: saturation check and reciprocal product
      sat_r[c]  <= (u_r[c] >= bcrn_pkg::NORM_SAT_U);
      u23_r[c]  <= u_r[c][22:0];
      prod_r[c] <= 40'(u_r[c][22:0]) * 40'(bcrn_pkg::RECIP_255);
      // s5: quotient correction, sign and clamp
      if (sat_r[c]) begin
        res[c] <= neg_r[c][3] ? bcrn_pkg::Q_NEG_MAX : bcrn_pkg::Q_POS_MAX;
      end else begin
        res[c] <= neg_r[c][3] ? -$signed(q) : $signed(q);
      end
    end
  end

  localparam int RECIP_SH_TOP = bcrn_pkg::RECIP_SH + 15;

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      done_r <= 1'b0;
    end else begin
      vld_r <= {vld_r[3:0], start};
      if (start) begin
        done_r <= 1'b0;
      end else if (vld_r[4]) begin
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;

endmodule

// ----- design/bilinear_crop_resize_normalise_top.sv -----
// Top level of the bilinear crop/resize/normalize block: config registers,
// request sequencer, frame store, coordinate dividers and normalizer (bcrn_pkg).
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | req_type, pixel x/y, RGB, dst x/y
//  out_    | output    | out_valid / out_ready| out_x, out_y, normalized RGB
//  cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
// A pixel write passes through the input buffer, then one frame store write.
// A request's time is set mostly by the serial coordinate divider; four frame
// store reads follow. An input buffer decouples the input; the output register
// waits on out_ready while the next item is already buffered. Reset is
// synchronous, active low.
module bilinear_crop_resize_normalise_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_DST    = 256,
  parameter int FRAC_BITS  = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_req_type,
  input  logic [8:0]                 in_pixel_x,
  input  logic [8:0]                 in_pixel_y,
  input  logic [7:0]                 in_red_in,
  input  logic [7:0]                 in_green_in,
  input  logic [7:0]                 in_blue_in,
  input  logic [7:0]                 in_dst_x,
  input  logic [7:0]                 in_dst_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_x,
  output logic [7:0]                 out_y,
  output logic signed [15:0]         out_norm_red,
  output logic signed [15:0]         out_norm_green,
  output logic signed [15:0]         out_norm_blue,
  input  logic                       cfg_we,
  input  logic [bcrn_pkg::CFG_IW-1:0] cfg_index,
  input  logic [bcrn_pkg::CFG_DW-1:0] cfg_data
);

  localparam int MAXWH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW    = $clog2(MAXWH);
  localparam int PW    = CW + 2;
  localparam int IW    = PW - 1;
  localparam int DW    = $clog2(MAX_DST + 1);
  localparam int MW    = PW + 10;
  localparam int FXW   = PW + FRAC_BITS;
  localparam int WW    = FRAC_BITS + 2;
  localparam int PRW   = 2 * WW;
  localparam int VW    = 2 * FRAC_BITS + 16;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers
  logic [9:0]  src_w_r, src_h_r;
  logic [8:0]  dst_w_r, dst_h_r;
  logic [11:0] crop_l_r, crop_t_r, crop_r_r, crop_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= bcrn_pkg::RST_SRC_W;
      src_h_r  <= bcrn_pkg::RST_SRC_H;
      dst_w_r  <= bcrn_pkg::RST_DST_W;
      dst_h_r  <= bcrn_pkg::RST_DST_H;
      crop_l_r <= bcrn_pkg::RST_CROP_L;
      crop_t_r <= bcrn_pkg::RST_CROP_T;
      crop_r_r <= bcrn_pkg::RST_CROP_R;
      crop_b_r <= bcrn_pkg::RST_CROP_B;
    end else if (cfg_we) begin
      case (bcrn_pkg::cfg_idx_t'(cfg_index))
        bcrn_pkg::CFG_SRC_W:  src_w_r  <= cfg_data[9:0];
        bcrn_pkg::CFG_SRC_H:  src_h_r  <= cfg_data[9:0];
        bcrn_pkg::CFG_DST_W:  dst_w_r  <= cfg_data[8:0];
        bcrn_pkg::CFG_DST_H:  dst_h_r  <= cfg_data[8:0];
        bcrn_pkg::CFG_CROP_L: crop_l_r <= cfg_data;
        bcrn_pkg::CFG_CROP_T: crop_t_r <= cfg_data;
        bcrn_pkg::CFG_CROP_R: crop_r_r <= cfg_data;
        bcrn_pkg::CFG_CROP_B: crop_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input buffer
  logic       ibuf_v_r;
  logic       ib_req_r;
  logic [8:0] ib_px_r, ib_py_r;
  logic [23:0] ib_rgb_r;
  logic [7:0] ib_dx_r, ib_dy_r;

  bcrn_pkg::ctl_t   ctl;
  bcrn_pkg::state_t state_r, state_nxt;

  assign in_ready = !ibuf_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ibuf_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      ibuf_v_r <= 1'b1;
    end else if (ctl.ibuf_pop) begin
      ibuf_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib_req_r <= in_req_type;
      ib_px_r  <= in_pixel_x;
      ib_py_r  <= in_pixel_y;
      ib_rgb_r <= {in_red_in, in_green_in, in_blue_in};
      ib_dx_r  <= in_dst_x;
      ib_dy_r  <= in_dst_y;
    end
  end

  // Crop clamping from the config registers
  logic [9:0]              sw, sh;
  logic [DW-1:0]           dw, dh;
  logic signed [RW_S-1:0]  cl, ct, cr, cb, rw, rh;
  logic                    req_ok;

  localparam int RW_S = bcrn_pkg::RW_W;

  always_comb begin
    sw = (32'(src_w_r) > MAX_WIDTH)  ? 10'(MAX_WIDTH)  : src_w_r;
    sh = (32'(src_h_r) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : src_h_r;
    dw = (32'(dst_w_r) > MAX_DST) ? DW'(MAX_DST) : DW'(dst_w_r);
    dh = (32'(dst_h_r) > MAX_DST) ? DW'(MAX_DST) : DW'(dst_h_r);
    cl = RW_S'($signed(crop_l_r));
    ct = RW_S'($signed(crop_t_r));
    cr = RW_S'($signed(crop_r_r));
    cb = RW_S'($signed(crop_b_r));
    if (cl < 0) cl = '0;
    if (ct < 0) ct = '0;
    if (cr > $signed({4'b0, sw})) cr = $signed({4'b0, sw});
    if (cb > $signed({4'b0, sh})) cb = $signed({4'b0, sh});
    rw = cr - cl;
    rh = cb - ct;
    req_ok = (rw > 0) && (rh > 0) && (dw != '0) && (dh != '0)
             && (32'(ib_dx_r) < 32'(dw)) && (32'(ib_dy_r) < 32'(dh));
  end

  // Request datapath registers
  logic                   ok_r;
  logic [7:0]             dx_r, dy_r;
  logic signed [PW-1:0]   rw_r, rh_r;
  logic [CW-1:0]          cl_r, ct_r;
  logic [DW-1:0]          dw_r, dh_r;
  logic signed [MW-1:0]   numx_r, numy_r;
  logic [CW-1:0]          col0_r, col1_r, row0_r, row1_r;
  logic signed [WW-1:0]   wx0_r, wx1_r, wy0_r, wy1_r;
  logic signed [PRW-1:0]  wxy_r [4];
  logic signed [VW-1:0]   acc_r [3];

  logic                   divx_done, divy_done;
  logic signed [FXW-1:0]  fx, fy;
  logic [23:0]            mem_rdata;
  logic [AW-1:0]          mem_addr;
  logic                   norm_done;
  logic signed [15:0]     norm_res [3];

  // Sample coordinate split into index and weight
  logic [IW-1:0]        x0, y0, x0p1, y0p1, x1, y1;
  logic signed [WW-1:0] ax, ay;

  always_comb begin
    x0   = fx[FXW-1] ? '0 : IW'(fx >>> FRAC_BITS);
    y0   = fy[FXW-1] ? '0 : IW'(fy >>> FRAC_BITS);
    x0p1 = x0 + IW'(1);
    y0p1 = y0 + IW'(1);
    x1   = ($signed({1'b0, x0p1}) >= rw_r) ? IW'(rw_r - PW'(1)) : x0p1;
    y1   = ($signed({1'b0, y0p1}) >= rh_r) ? IW'(rh_r - PW'(1)) : y0p1;
    ax   = WW'(fx - (FXW'(x0) << FRAC_BITS));
    ay   = WW'(fy - (FXW'(y0) << FRAC_BITS));
  end

  // Weight picked for the pixel arriving from the frame store
  logic signed [PRW-1:0] wsel;
  logic [7:0]            pix [3];

  always_comb begin
    case (state_r)
      bcrn_pkg::ST_RD1: wsel = wxy_r[0];
      bcrn_pkg::ST_RD2: wsel = wxy_r[1];
      bcrn_pkg::ST_RD3: wsel = wxy_r[2];
      default:          wsel = wxy_r[3];
    endcase
    pix[0] = mem_rdata[23:16];
    pix[1] = mem_rdata[15:8];
    pix[2] = mem_rdata[7:0];
  end

  // Datapath registers, loaded by state
  always_ff @(posedge clk) begin
    case (state_r)
      bcrn_pkg::ST_IDLE: begin
        ok_r <= req_ok;
        dx_r <= ib_dx_r;
        dy_r <= ib_dy_r;
        rw_r <= PW'(rw);
        rh_r <= PW'(rh);
        cl_r <= CW'(cl);
        ct_r <= CW'(ct);
        dw_r <= dw;
        dh_r <= dh;
      end
      bcrn_pkg::ST_SETUP: begin
        numx_r <= MW'($signed({2'b0, dx_r, 1'b1})) * MW'(rw_r) - MW'($signed({1'b0, dw_r}));
        numy_r <= MW'($signed({2'b0, dy_r, 1'b1})) * MW'(rh_r) - MW'($signed({1'b0, dh_r}));
      end
      bcrn_pkg::ST_POS: begin
        col0_r <= cl_r + CW'(x0);
        col1_r <= cl_r + CW'(x1);
        row0_r <= ct_r + CW'(y0);
        row1_r <= ct_r + CW'(y1);
        wx0_r  <= (WW'(1) << FRAC_BITS) - ax;
        wx1_r  <= ax;
        wy0_r  <= (WW'(1) << FRAC_BITS) - ay;
        wy1_r  <= ay;
      end
      bcrn_pkg::ST_WGT: begin
        wxy_r[0] <= PRW'(wx0_r) * PRW'(wy0_r);
        wxy_r[1] <= PRW'(wx1_r) * PRW'(wy0_r);
        wxy_r[2] <= PRW'(wx0_r) * PRW'(wy1_r);
        wxy_r[3] <= PRW'(wx1_r) * PRW'(wy1_r);
        for (int c = 0; c < 3; c++) begin
          acc_r[c] <= '0;
        end
      end
      bcrn_pkg::ST_RD1, bcrn_pkg::ST_RD2, bcrn_pkg::ST_RD3, bcrn_pkg::ST_ACC: begin
        for (int c = 0; c < 3; c++) begin
          acc_r[c] <= acc_r[c] + VW'($signed({1'b0, pix[c]}) * wsel);
        end
      end
      default: ;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bcrn_pkg::ST_IDLE:  if (ibuf_v_r && ib_req_r == bcrn_pkg::REQ_READ) begin
        state_nxt = bcrn_pkg::ST_SETUP;
      end
      bcrn_pkg::ST_SETUP: state_nxt = ok_r ? bcrn_pkg::ST_START : bcrn_pkg::ST_DONE;
      bcrn_pkg::ST_START: state_nxt = bcrn_pkg::ST_DIV;
      bcrn_pkg::ST_DIV:   if (divx_done && divy_done) begin
        state_nxt = bcrn_pkg::ST_POS;
      end
      bcrn_pkg::ST_POS:   state_nxt = bcrn_pkg::ST_WGT;
      bcrn_pkg::ST_WGT:   state_nxt = bcrn_pkg::ST_RD0;
      bcrn_pkg::ST_RD0:   state_nxt = bcrn_pkg::ST_RD1;
      bcrn_pkg::ST_RD1:   state_nxt = bcrn_pkg::ST_RD2;
      bcrn_pkg::ST_RD2:   state_nxt = bcrn_pkg::ST_RD3;
      bcrn_pkg::ST_RD3:   state_nxt = bcrn_pkg::ST_ACC;
      bcrn_pkg::ST_ACC:   state_nxt = bcrn_pkg::ST_NORM;
      bcrn_pkg::ST_NORM:  state_nxt = bcrn_pkg::ST_NWAIT;
      bcrn_pkg::ST_NWAIT: if (norm_done) begin
        state_nxt = bcrn_pkg::ST_DONE;
      end
      bcrn_pkg::ST_DONE:  if (!out_valid || out_ready) begin
        state_nxt = bcrn_pkg::ST_IDLE;
      end
      default:            state_nxt = bcrn_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  logic wr_in_range;
  logic [CW-1:0] rd_row, rd_col;

  assign wr_in_range = (32'(ib_px_r) < MAX_WIDTH) && (32'(ib_py_r) < MAX_HEIGHT);

  always_comb begin
    ctl    = '0;
    rd_row = row0_r;
    rd_col = col0_r;
    case (state_r)
      bcrn_pkg::ST_IDLE: begin
        ctl.ibuf_pop = ibuf_v_r;
        ctl.mem_we   = ibuf_v_r && (ib_req_r == bcrn_pkg::REQ_WRITE) && wr_in_range;
      end
      bcrn_pkg::ST_START: ctl.div_start  = 1'b1;
      bcrn_pkg::ST_RD1:   rd_col = col1_r;
      bcrn_pkg::ST_RD2:   rd_row = row1_r;
      bcrn_pkg::ST_RD3: begin
        rd_row = row1_r;
        rd_col = col1_r;
      end
      bcrn_pkg::ST_NORM:  ctl.norm_start = 1'b1;
      bcrn_pkg::ST_DONE:  ctl.out_load   = !out_valid || out_ready;
      default: ;
    endcase
    if (state_r == bcrn_pkg::ST_IDLE) begin
      mem_addr = AW'(32'(ib_py_r) * MAX_WIDTH + 32'(ib_px_r));
    end else begin
      mem_addr = AW'(32'(rd_row) * MAX_WIDTH + 32'(rd_col));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcrn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register
  logic               out_valid_r;
  logic [7:0]         out_x_r, out_y_r;
  logic signed [15:0] out_r_r, out_g_r, out_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_x_r <= dx_r;
      out_y_r <= dy_r;
      out_r_r <= ok_r ? norm_res[0] : '0;
      out_g_r <= ok_r ? norm_res[1] : '0;
      out_b_r <= ok_r ? norm_res[2] : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_norm_red   = out_r_r;
  assign out_norm_green = out_g_r;
  assign out_norm_blue  = out_b_r;

  // Units
  bcrn_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (ctl.mem_we),
    .addr  (mem_addr),
    .wdata (ib_rgb_r),
    .rdata (mem_rdata)
  );

  bcrn_pos_div #(
    .MW        (MW),
    .DIVW      (DW + 1),
    .FRAC_BITS (FRAC_BITS),
    .FXW       (FXW)
  ) u_divx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (numx_r),
    .div   ({dw_r, 1'b0}),
    .done  (divx_done),
    .fx    (fx)
  );

  bcrn_pos_div #(
    .MW        (MW),
    .DIVW      (DW + 1),
    .FRAC_BITS (FRAC_BITS),
    .FXW       (FXW)
  ) u_divy (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (numy_r),
    .div   ({dh_r, 1'b0}),
    .done  (divy_done),
    .fx    (fy)
  );

  bcrn_norm #(
    .FRAC_BITS (FRAC_BITS),
    .VW        (VW)
  ) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.norm_start),
    .acc   (acc_r),
    .done  (norm_done),
    .res   (norm_res)
  );

endmodule

// ----- design/bcrn_checker.sv -----
// Port-level checker for the bilinear crop/resize/normalize top level, plus its bind.
// Depends only on the top level's ports.
module bcrn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_req_type,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         out_x,
  input logic [7:0]         out_y,
  input logic signed [15:0] out_norm_red
);

  // Requests taken whose result has not yet been taken
  logic [2:0] pend_r, pend_nxt;
  logic       req_acc, res_acc;

  assign req_acc = in_valid && in_ready && in_req_type;
  assign res_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (req_acc && !res_acc) pend_nxt = pend_r + 3'd1;
    if (!req_acc && res_acc) pend_nxt = pend_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_norm_red))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result without an outstanding request");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("more requests in flight than the block can hold");

endmodule

bind bilinear_crop_resize_normalise_top bcrn_checker u_bcrn_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_req_type  (in_req_type),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_x        (out_x),
  .out_y        (out_y),
  .out_norm_red (out_norm_red)
);
